>>> rtl/i2cdw_pkg.sv
// i2cdw_pkg: types, codes and helpers shared by the I2C display byte writer.
// No dependencies.
package i2cdw_pkg;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned DELAY_W    = 11;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TICKS_PER_US   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ACK_TIMEOUT    = 2'd2;

  // request codes
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_CMD  = 2'd1;
  localparam logic [1:0] REQ_DATA = 2'd2;

  // control bytes sent ahead of the payload
  localparam logic [7:0] CTRL_CMD  = 8'h00;
  localparam logic [7:0] CTRL_DATA = 8'h40;

  // reset values of the configuration registers
  localparam logic [7:0] RST_DEVICE_ADDRESS = 8'h78;
  localparam logic [7:0] RST_TICKS_PER_US   = 8'd1;
  localparam logic [7:0] RST_ACK_TIMEOUT    = 8'd250;

  // bus delay lengths in microseconds
  localparam logic [2:0] US_0 = 3'd0;
  localparam logic [2:0] US_1 = 3'd1;
  localparam logic [2:0] US_2 = 3'd2;
  localparam logic [2:0] US_4 = 3'd4;

  typedef struct packed {
    logic [7:0] device_address;
    logic [7:0] ticks_per_us;
    logic [7:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] byte_value;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic scl;
    logic sda_out;
    logic sda_drive;
    logic busy_res;
    logic done_res;
    logic ack_error;
  } res_t;

  // ticks of a delay of us microseconds, by shifts only
  function automatic logic [DELAY_W-1:0] delay_ticks(input logic [7:0] tpu,
                                                     input logic [2:0] us);
    logic [DELAY_W-1:0] d;
    d = '0;
    case (us)
      US_4:    d = {1'b0, tpu, 2'b00};
      US_2:    d = {2'b00, tpu, 1'b0};
      US_1:    d = {3'b000, tpu};
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/i2cdw_cfg.sv
// i2cdw_cfg: configuration registers of the I2C display byte writer.
// Depends on i2cdw_pkg.
module i2cdw_cfg
  import i2cdw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [7:0]            cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address <= RST_DEVICE_ADDRESS;
      cfg_r.ticks_per_us   <= RST_TICKS_PER_US;
      cfg_r.ack_timeout    <= RST_ACK_TIMEOUT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_DEVICE_ADDRESS: cfg_r.device_address <= cfg_wdata;
        CFG_TICKS_PER_US:   cfg_r.ticks_per_us   <= cfg_wdata;
        CFG_ACK_TIMEOUT:    cfg_r.ack_timeout    <= cfg_wdata;
        default:            ; // index beyond the list: drop
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/i2cdw_seq.sv
// i2cdw_seq: bus sequencer state and the one-tick update of the I2C writer.
// Depends on i2cdw_pkg.
module i2cdw_seq
  import i2cdw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic step_en,
  input  req_t req,
  input  cfg_t cfg,
  output res_t res
);

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_ST1   = 4'd1;
  localparam logic [3:0] PH_ST2   = 4'd2;
  localparam logic [3:0] PH_BSET  = 4'd3;
  localparam logic [3:0] PH_BHI   = 4'd4;
  localparam logic [3:0] PH_BLO   = 4'd5;
  localparam logic [3:0] PH_ASET  = 4'd6;
  localparam logic [3:0] PH_AHI   = 4'd7;
  localparam logic [3:0] PH_AWAIT = 4'd8;
  localparam logic [3:0] PH_SPL   = 4'd9;
  localparam logic [3:0] PH_SPH   = 4'd10;
  localparam logic [3:0] PH_SPL_E = 4'd11;
  localparam logic [3:0] PH_SPH_E = 4'd12;

  logic [3:0]         phase_r, phase_nxt;
  logic [1:0]         slot_r, slot_nxt;
  logic [2:0]         bit_r, bit_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [7:0]         payload_r, payload_nxt;
  logic               is_data_r, is_data_nxt;
  logic [DELAY_W-1:0] delay_r, delay_nxt;
  logic [7:0]         wait_r, wait_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;
  logic [1:0]         next_slot;
  logic [7:0]         next_byte;
  logic               done, err, released;

  // byte of the slot after the current one
  always_comb begin
    next_slot = slot_r + 2'd1;
    case (next_slot)
      2'd1:    next_byte = is_data_r ? CTRL_DATA : CTRL_CMD;
      default: next_byte = payload_r;
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    slot_nxt    = slot_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    payload_nxt = payload_r;
    is_data_nxt = is_data_r;
    delay_nxt   = delay_r;
    wait_nxt    = wait_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    done        = 1'b0;
    err         = 1'b0;
    if (phase_r == PH_IDLE) begin
      scl_nxt = 1'b1;
      sda_nxt = 1'b1;
      if (req.req_type == REQ_CMD || req.req_type == REQ_DATA) begin
        payload_nxt = req.byte_value;
        is_data_nxt = (req.req_type == REQ_DATA);
        slot_nxt    = 2'd0;
        bit_nxt     = 3'd0;
        wait_nxt    = 8'd0;
        phase_nxt   = PH_ST1;
        delay_nxt   = delay_ticks(cfg.ticks_per_us, US_4);
      end
    end else if (phase_r == PH_AWAIT) begin
      if (!req.sda_in) begin
        if (slot_r < 2'd2) begin
          slot_nxt  = next_slot;
          shift_nxt = next_byte;
          bit_nxt   = 3'd0;
          phase_nxt = PH_BSET;
          scl_nxt   = 1'b0;
          sda_nxt   = next_byte[7];
          delay_nxt = delay_ticks(cfg.ticks_per_us, US_2);
        end else begin
          phase_nxt = PH_SPL;
          scl_nxt   = 1'b0;
          sda_nxt   = 1'b0;
          delay_nxt = delay_ticks(cfg.ticks_per_us, US_4);
        end
      end else if (wait_r >= cfg.ack_timeout) begin
        phase_nxt = PH_SPL_E;
        scl_nxt   = 1'b0;
        sda_nxt   = 1'b0;
        delay_nxt = delay_ticks(cfg.ticks_per_us, US_4);
      end else begin
        wait_nxt = wait_r + 8'd1;
      end
    end else if (phase_r > PH_SPH_E) begin
      phase_nxt = PH_IDLE;
      scl_nxt   = 1'b1;
      sda_nxt   = 1'b1;
    end else if (delay_r > DELAY_W'(1)) begin
      delay_nxt = delay_r - DELAY_W'(1);
    end else begin
      unique case (phase_r)
        PH_ST1: begin
          phase_nxt = PH_ST2;
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b0;
          delay_nxt = delay_ticks(cfg.ticks_per_us, US_4);
        end
        PH_ST2: begin
          slot_nxt  = 2'd0;
          shift_nxt = cfg.device_address;
          bit_nxt   = 3'd0;
          phase_nxt = PH_BSET;
          scl_nxt   = 1'b0;
          sda_nxt   = cfg.device_address[7];
          delay_nxt = delay_ticks(cfg.ticks_per_us, US_2);
        end
        PH_BSET: begin
          phase_nxt = PH_BHI;
          scl_nxt   = 1'b1;
          delay_nxt = delay_ticks(cfg.ticks_per_us, US_2);
        end
        PH_BHI: begin
          phase_nxt = PH_BLO;
          scl_nxt   = 1'b0;
          delay_nxt = delay_ticks(cfg.ticks_per_us, US_2);
        end
        PH_BLO: begin
          if (bit_r == 3'd7) begin
            phase_nxt = PH_ASET;
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b1;
            delay_nxt = delay_ticks(cfg.ticks_per_us, US_1);
          end else begin
            bit_nxt   = bit_r + 3'd1;
            shift_nxt = {shift_r[6:0], 1'b0};
            phase_nxt = PH_BSET;
            scl_nxt   = 1'b0;
            sda_nxt   = shift_r[6];
            delay_nxt = delay_ticks(cfg.ticks_per_us, US_2);
          end
        end
        PH_ASET: begin
          phase_nxt = PH_AHI;
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          delay_nxt = delay_ticks(cfg.ticks_per_us, US_1);
        end
        PH_AHI: begin
          wait_nxt  = 8'd0;
          phase_nxt = PH_AWAIT;
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          delay_nxt = delay_ticks(cfg.ticks_per_us, US_0);
        end
        PH_SPL: begin
          phase_nxt = PH_SPH;
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          delay_nxt = delay_ticks(cfg.ticks_per_us, US_4);
        end
        PH_SPL_E: begin
          phase_nxt = PH_SPH_E;
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          delay_nxt = delay_ticks(cfg.ticks_per_us, US_4);
        end
        PH_SPH, PH_SPH_E: begin
          err       = (phase_r == PH_SPH_E);
          done      = 1'b1;
          phase_nxt = PH_IDLE;
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          delay_nxt = '0;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      slot_r    <= 2'd0;
      bit_r     <= 3'd0;
      shift_r   <= 8'd0;
      payload_r <= 8'd0;
      is_data_r <= 1'b0;
      delay_r   <= '0;
      wait_r    <= 8'd0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      slot_r    <= slot_nxt;
      bit_r     <= bit_nxt;
      shift_r   <= shift_nxt;
      payload_r <= payload_nxt;
      is_data_r <= is_data_nxt;
      delay_r   <= delay_nxt;
      wait_r    <= wait_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
    end
  end

  assign released = (phase_nxt == PH_ASET) || (phase_nxt == PH_AHI) ||
                    (phase_nxt == PH_AWAIT);

  always_comb begin
    res.scl       = scl_nxt;
    res.sda_out   = released ? 1'b1 : sda_nxt;
    res.sda_drive = !released;
    res.busy_res  = (phase_nxt != PH_IDLE);
    res.done_res  = done;
    res.ack_error = err;
  end

endmodule

>>> rtl/i2c_display_byte_writer.sv
// i2c_display_byte_writer: top level of the I2C display byte writer.
// Depends on i2cdw_pkg, i2cdw_cfg and i2cdw_seq.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in      | in        | in_valid / in_stall  | req_type, byte_value, sda_in
//  out     | out       | out_valid / out_stall| scl, sda_out, sda_drive, busy_res,
//          |           |                      | done_res, ack_error
//  cfg     | in        | cfg_we               | cfg_addr, cfg_wdata
//
// One request per clock cycle is accepted while in_stall is low. Each request
// waits in the input register; its result is loaded into the result register.
// Each request is one bus tick; the sequencer update runs as the request
// moves from the input register into the result register.
// Reset (rst_n low, synchronous) empties both registers, idles the bus
// with SCL and SDA high and loads the configuration reset values.
// A stall on a valid result holds both registers if the input one is full; the
// input register takes a request while empty or the result one is free or read.
module i2c_display_byte_writer
  import i2cdw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_req_type,
  input  logic [7:0]            in_byte_value,
  input  logic                  in_sda_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_scl,
  output logic                  out_sda_out,
  output logic                  out_sda_drive,
  output logic                  out_busy_res,
  output logic                  out_done_res,
  output logic                  out_ack_error,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [7:0]            cfg_wdata
);

  cfg_t cfg;
  req_t req_r;
  logic in_valid_r;
  res_t res;
  res_t res_r;
  logic out_valid_r;
  logic advance;

  i2cdw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // advance the held request into the result register when it has room
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  i2cdw_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .req     (req_r),
    .cfg     (cfg),
    .res     (res)
  );

  // input register: take a request when empty or when the held one moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r.req_type   <= in_req_type;
      req_r.byte_value <= in_byte_value;
      req_r.sda_in     <= in_sda_in;
    end
  end

  // result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scl       = res_r.scl;
  assign out_sda_out   = res_r.sda_out;
  assign out_sda_drive = res_r.sda_drive;
  assign out_busy_res  = res_r.busy_res;
  assign out_done_res  = res_r.done_res;
  assign out_ack_error = res_r.ack_error;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for the I2C display byte writer.
// Depends on i2cdw_pkg and i2c_display_byte_writer.
module tb_top;
  import i2cdw_pkg::*;

  localparam int unsigned HALF_PERIOD = 5;
  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned LIMIT_NS = 10_000_000;
  localparam int unsigned TAIL_CYCLES = 10;
  localparam int unsigned DRAIN_CHUNK = 8;
  // spare request code; the block treats it as a plain tick
  localparam logic [1:0] REQ_SPARE = 2'd3;

  // bus sequencer phases, in the block's own order
  typedef enum logic [3:0] {
    BUS_IDLE, BUS_START_HI, BUS_START_LO, BUS_BIT_SETUP, BUS_BIT_HIGH,
    BUS_BIT_LOW, BUS_ACK_SETUP, BUS_ACK_HIGH, BUS_ACK_WAIT, BUS_STOP_LO,
    BUS_STOP_HI, BUS_ABORT_LO, BUS_ABORT_HI
  } bus_phase_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_req_type = REQ_TICK;
  logic [7:0]            in_byte_value = 8'h00;
  logic                  in_sda_in = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_scl;
  logic                  out_sda_out;
  logic                  out_sda_drive;
  logic                  out_busy_res;
  logic                  out_done_res;
  logic                  out_ack_error;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = CFG_DEVICE_ADDRESS;
  logic [7:0]            cfg_wdata = 8'h00;

  // requests waiting for the driver, and line states waiting for the monitor
  req_t pending_reqs [$];
  res_t expected_lines [$];

  int unsigned idle_pct = 23;
  int unsigned stall_pct = 23;
  int unsigned sda_high_pct = 15;
  int unsigned mismatch_count = 0;

  string line_names [6] = '{"scl", "sda_out", "sda_drive", "busy_res", "done_res",
                            "ack_error"};

  // predictor's copy of the registers and of the bus sequencer
  logic [7:0]         cfg_dev_addr = RST_DEVICE_ADDRESS;
  logic [7:0]         cfg_tpu = RST_TICKS_PER_US;
  logic [7:0]         cfg_timeout = RST_ACK_TIMEOUT;
  bus_phase_e         bus_phase = BUS_IDLE;
  logic [1:0]         bus_slot = 2'd0;
  logic [2:0]         bus_bit = 3'd0;
  logic [7:0]         bus_shift = 8'h00;
  logic [7:0]         bus_payload = 8'h00;
  logic               bus_is_data = 1'b0;
  logic [DELAY_W-1:0] bus_delay = '0;
  logic [7:0]         bus_ack_wait = 8'h00;
  logic               bus_scl = 1'b1;
  logic               bus_sda = 1'b1;

  i2c_display_byte_writer dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_byte_value (in_byte_value),
    .in_sda_in     (in_sda_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_scl       (out_scl),
    .out_sda_out   (out_sda_out),
    .out_sda_drive (out_sda_drive),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_ack_error (out_ack_error),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // Enter a timed phase: set both line levels now, load its length in ticks.
  function automatic void enter_phase(bus_phase_e p, logic scl, logic sda, logic [2:0] us);
    bus_phase = p;
    bus_scl = scl;
    bus_sda = sda;
    bus_delay = DELAY_W'(us) * DELAY_W'(cfg_tpu);
  endfunction

  // Load the byte of a slot (address, control, payload) and set up its first bit.
  function automatic void load_byte(logic [1:0] slot);
    bus_slot = slot;
    case (slot)
      2'd0:    bus_shift = cfg_dev_addr;
      2'd1:    bus_shift = bus_is_data ? CTRL_DATA : CTRL_CMD;
      default: bus_shift = bus_payload;
    endcase
    bus_bit = 3'd0;
    enter_phase(BUS_BIT_SETUP, 1'b0, bus_shift[7], US_2);
  endfunction

  // Advance the sequencer by one bus tick and give the line state it drives.
  function automatic res_t bus_tick(logic [1:0] rtype, logic [7:0] val, logic sda);
    res_t r;
    logic released;
    r.done_res = 1'b0;
    r.ack_error = 1'b0;
    if (bus_phase == BUS_IDLE) begin
      bus_scl = 1'b1;
      bus_sda = 1'b1;
      if (rtype == REQ_CMD || rtype == REQ_DATA) begin
        bus_payload = val;
        bus_is_data = (rtype == REQ_DATA);
        bus_slot = 2'd0;
        bus_bit = 3'd0;
        bus_ack_wait = 8'h00;
        enter_phase(BUS_START_HI, 1'b1, 1'b1, US_4);
      end
    end else if (bus_phase == BUS_ACK_WAIT) begin
      // slave pulls SDA low: next byte, or stop after the payload
      if (!sda) begin
        if (bus_slot < 2'd2) load_byte(bus_slot + 2'd1);
        else enter_phase(BUS_STOP_LO, 1'b0, 1'b0, US_4);
      end else if (bus_ack_wait >= cfg_timeout) begin
        enter_phase(BUS_ABORT_LO, 1'b0, 1'b0, US_4);
      end else begin
        bus_ack_wait = bus_ack_wait + 8'd1;
      end
    end else if (bus_delay > DELAY_W'(1)) begin
      bus_delay = bus_delay - DELAY_W'(1);
    end else begin
      case (bus_phase)
        BUS_START_HI:  enter_phase(BUS_START_LO, 1'b1, 1'b0, US_4);
        BUS_START_LO:  load_byte(2'd0);
        BUS_BIT_SETUP: enter_phase(BUS_BIT_HIGH, 1'b1, bus_sda, US_2);
        BUS_BIT_HIGH:  enter_phase(BUS_BIT_LOW, 1'b0, bus_sda, US_2);
        BUS_BIT_LOW: begin
          if (bus_bit == 3'd7) begin
            enter_phase(BUS_ACK_SETUP, 1'b0, 1'b1, US_1);
          end else begin
            bus_bit = bus_bit + 3'd1;
            bus_shift = bus_shift << 1;
            enter_phase(BUS_BIT_SETUP, 1'b0, bus_shift[7], US_2);
          end
        end
        BUS_ACK_SETUP: enter_phase(BUS_ACK_HIGH, 1'b1, 1'b1, US_1);
        BUS_ACK_HIGH: begin
          bus_ack_wait = 8'h00;
          enter_phase(BUS_ACK_WAIT, 1'b1, 1'b1, US_0);
        end
        BUS_STOP_LO:   enter_phase(BUS_STOP_HI, 1'b1, 1'b1, US_4);
        BUS_ABORT_LO:  enter_phase(BUS_ABORT_HI, 1'b1, 1'b1, US_4);
        BUS_STOP_HI, BUS_ABORT_HI: begin
          r.ack_error = (bus_phase == BUS_ABORT_HI);
          r.done_res = 1'b1;
          bus_phase = BUS_IDLE;
          bus_scl = 1'b1;
          bus_sda = 1'b1;
          bus_delay = '0;
        end
        default: bus_phase = BUS_IDLE;
      endcase
    end
    // SDA is released throughout the acknowledge slot
    released = (bus_phase == BUS_ACK_SETUP || bus_phase == BUS_ACK_HIGH ||
                bus_phase == BUS_ACK_WAIT);
    r.scl = bus_scl;
    r.sda_out = released ? 1'b1 : bus_sda;
    r.sda_drive = !released;
    r.busy_res = (bus_phase != BUS_IDLE);
    return r;
  endfunction

  // Mirror register writes into the predictor on the edge the block takes them.
  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      case (cfg_addr)
        CFG_DEVICE_ADDRESS: cfg_dev_addr <= cfg_wdata;
        CFG_TICKS_PER_US:   cfg_tpu <= cfg_wdata;
        CFG_ACK_TIMEOUT:    cfg_timeout <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Driver: predict each accepted request, then offer the next one or idle.
  always @(posedge clk) begin : request_driver
    req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_lines.push_back(bus_tick(in_req_type, in_byte_value, in_sda_in));
      // hold the payload while stalled; otherwise move on
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_req_type <= nxt.req_type;
          in_byte_value <= nxt.byte_value;
          in_sda_in <= nxt.sda_in;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted line state with the oldest expectation.
  always @(posedge clk) begin : line_monitor
    res_t got;
    res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_scl, out_sda_out, out_sda_drive, out_busy_res, out_done_res,
                out_ack_error};
        if (expected_lines.size() == 0) begin
          $display("%0t: unexpected line state %b, nothing expected", $time, got);
          mismatch_count++;
        end else begin
          want = expected_lines.pop_front();
          for (int i = 0; i < 6; i++) begin
            if (got[5-i] !== want[5-i]) begin
              $display("%0t: %s expected %b actual %b", $time, line_names[i],
                       want[5-i], got[5-i]);
              mismatch_count++;
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic push_item(logic [1:0] rtype, logic [7:0] val, logic sda);
    req_t rq;
    rq.req_type = rtype;
    rq.byte_value = val;
    rq.sda_in = sda;
    pending_reqs.push_back(rq);
  endtask

  // Hold off until every request is taken and every result has come back.
  task automatic settle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_lines.size() != 0);
  endtask

  // Feed acknowledging ticks until the predicted bus is idle again.
  task automatic drain_bus();
    settle();
    while (bus_phase != BUS_IDLE) begin
      repeat (DRAIN_CHUNK) push_item(REQ_TICK, 8'($urandom), 1'b0);
      settle();
    end
  endtask

  // Only call with nothing in flight.
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly well-formed traffic: a request followed by a run of ticks, with
  // stray requests (often ignored while busy) and acks refused at random.
  task automatic random_traffic(int unsigned n_items);
    int unsigned made;
    int unsigned run;
    logic [1:0] rt;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(9) == 0) rt = 2'($urandom_range(3));
      else rt = $urandom_range(1) ? REQ_DATA : REQ_CMD;
      push_item(rt, 8'($urandom), 1'($urandom));
      run = $urandom_range(200, 20);
      for (int k = 0; k < run; k++) begin
        push_item(($urandom_range(19) == 0) ? 2'($urandom_range(3)) : REQ_TICK,
                  8'($urandom), ($urandom_range(99) < sda_high_pct));
      end
      made += run + 1;
    end
    drain_bus();
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: an idle tick, the spare code, a command under reset settings
    // with a data request arriving while busy.
    push_item(REQ_TICK, 8'hFF, 1'b1);
    push_item(REQ_SPARE, 8'h81, 1'b0);
    push_item(REQ_CMD, 8'h00, 1'b0);
    push_item(REQ_TICK, 8'h00, 1'b0);
    push_item(REQ_DATA, 8'hFF, 1'b1);
    drain_bus();

    // Zero-length delays and zero timeout: the first refused ack aborts.
    write_reg(CFG_TICKS_PER_US, 8'd0);
    write_reg(CFG_ACK_TIMEOUT, 8'd0);
    write_reg(CFG_DEVICE_ADDRESS, 8'hFF);
    push_item(REQ_DATA, 8'hFF, 1'b1);
    repeat (40) push_item(REQ_TICK, 8'h00, 1'b1);
    drain_bus();
    push_item(REQ_CMD, 8'hA5, 1'b0);
    drain_bus();
    write_reg(CFG_DEVICE_ADDRESS, 8'h00);
    push_item(REQ_DATA, 8'h5A, 1'b0);
    drain_bus();

    // Longest ack wait before the abort.
    write_reg(CFG_ACK_TIMEOUT, 8'd255);
    push_item(REQ_CMD, 8'h3C, 1'b1);
    repeat (300) push_item(REQ_TICK, 8'hC3, 1'b1);
    drain_bus();

    // Random phases with zero-length delays and small timeouts.
    write_reg(CFG_ACK_TIMEOUT, 8'($urandom_range(4, 1)));
    write_reg(CFG_DEVICE_ADDRESS, 8'($urandom));
    sda_high_pct = 40;
    random_traffic(120);

    // long stretch with no idling on either side: several ticks per
    // microsecond and the address refused at once
    write_reg(CFG_TICKS_PER_US, 8'd3);
    write_reg(CFG_ACK_TIMEOUT, 8'd0);
    write_reg(CFG_DEVICE_ADDRESS, RST_DEVICE_ADDRESS);
    idle_pct = 0;
    stall_pct = 0;
    push_item(REQ_CMD, 8'($urandom), 1'b1);
    repeat (210) push_item(REQ_TICK, 8'($urandom), 1'b1);
    drain_bus();
    idle_pct = 23;
    stall_pct = 23;

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_lines.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Drop out if the run hangs.
  initial begin : watchdog
    #(LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> filelist.f
rtl/i2cdw_pkg.sv
rtl/i2cdw_cfg.sv
rtl/i2cdw_seq.sv
rtl/i2c_display_byte_writer.sv
sim/tb_top.sv
